>>> rtl/core/frm_pkg.sv
package frm_pkg;

  localparam int WINDOW_LEN = 64;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

  localparam int TIME_W     = 16;
  localparam int SUM_W      = TIME_W + SLOT_W;
  // avg dividend is sum << 8, the widest of the three divisions
  localparam int DVD_W      = SUM_W + 8;
  localparam int DVS_W      = SUM_W;
  localparam int CNT_W      = $clog2(DVD_W);

  localparam int AVG_W      = 24;
  localparam int RATE_W     = 18;
  localparam int WAIT_W     = 10;
  localparam int IDLE_W     = 16;
  localparam int FRAMES_W   = 32;
  localparam int TARGET_W   = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RATE_W-1:0]   RATE_LIMIT     = 18'd256000;
  localparam logic [TARGET_W-1:0] PERIOD_NUM     = 10'd1000;
  localparam logic [IDLE_W-1:0]   IDLE_LIMIT_RST = 16'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 2'd2;

  typedef enum logic [1:0] {
    OP_AVG,
    OP_RATE,
    OP_LIM
  } op_e;

  typedef struct packed {
    logic cap_in;
    logic update;
    logic div_start;
    logic cap;
    logic zero;
    op_e  op;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sum_zero;
    logic wait_needed;
  } ctrl_status_t;

endpackage

>>> rtl/core/frm_ram.sv
module frm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/frm_div.sv
// Restoring divider, one quotient bit per cycle.
module frm_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [frm_pkg::DVD_W-1:0] dividend_i,
  input  logic [frm_pkg::DVS_W-1:0] divisor_i,
  output logic                    done_o,
  output logic [frm_pkg::DVD_W-1:0] quot_o
);

  logic                      busy_q;
  logic                      done_q;
  logic [frm_pkg::CNT_W-1:0] cnt_q;
  logic [frm_pkg::DVS_W-1:0] rem_q;
  logic [frm_pkg::DVS_W-1:0] rem_d;
  logic [frm_pkg::DVS_W-1:0] dvs_q;
  logic [frm_pkg::DVD_W-1:0] quo_q;
  logic [frm_pkg::DVS_W:0]   shifted;
  logic                      ge;
  logic                      last;

  assign shifted = {rem_q, quo_q[frm_pkg::DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign rem_d   = ge ? frm_pkg::DVS_W'(shifted - {1'b0, dvs_q})
                      : shifted[frm_pkg::DVS_W-1:0];
  assign last    = cnt_q == frm_pkg::CNT_W'(frm_pkg::DVD_W - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[frm_pkg::DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/core/frm_dpath.sv
module frm_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  frm_pkg::ctrl_cmd_t              cmd_i,
  output frm_pkg::ctrl_status_t           status_o,
  input  logic [frm_pkg::TIME_W-1:0]      frame_elapsed_i,
  input  logic                            redraw_requested_i,
  input  logic                            cfg_we_i,
  input  logic [frm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [frm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [frm_pkg::AVG_W-1:0]       average_time_q8_o,
  output logic [frm_pkg::RATE_W-1:0]      rate_q8_o,
  output logic [frm_pkg::WAIT_W-1:0]      wait_time_o,
  output logic [frm_pkg::IDLE_W-1:0]      idle_count_o,
  output logic                            is_idle_o,
  output logic [frm_pkg::FRAMES_W-1:0]    frames_total_o
);

  // configuration
  logic [frm_pkg::TARGET_W-1:0] target_q;
  logic                         vsync_q;
  logic [frm_pkg::IDLE_W-1:0]   idle_limit_q;

  // window and counters
  logic [frm_pkg::SUM_W-1:0]    sum_q;
  logic [frm_pkg::SUM_W-1:0]    sum_d;
  logic [frm_pkg::SUM_W-1:0]    sum_base;
  logic [frm_pkg::FILL_W-1:0]   filled_q;
  logic [frm_pkg::SLOT_W-1:0]   slot_q;
  logic [frm_pkg::IDLE_W-1:0]   idle_frames_q;
  logic [frm_pkg::IDLE_W-1:0]   idle_frames_d;
  logic [frm_pkg::FRAMES_W-1:0] frame_cnt_q;
  logic                         full;

  // current word
  logic [frm_pkg::TIME_W-1:0]   elapsed_q;
  logic                         req_q;
  logic [frm_pkg::TIME_W-1:0]   old_time;

  // results
  logic [frm_pkg::AVG_W-1:0]    avg_q;
  logic [frm_pkg::RATE_W-1:0]   rate_q;
  logic [frm_pkg::WAIT_W-1:0]   wait_q;
  logic                         is_idle_q;

  // output register
  logic [frm_pkg::AVG_W-1:0]    avg_out_q;
  logic [frm_pkg::RATE_W-1:0]   rate_out_q;
  logic [frm_pkg::WAIT_W-1:0]   wait_out_q;
  logic [frm_pkg::IDLE_W-1:0]   idle_out_q;
  logic                         is_idle_out_q;
  logic [frm_pkg::FRAMES_W-1:0] frames_out_q;

  // divider
  logic [frm_pkg::DVD_W-1:0]    dvd;
  logic [frm_pkg::DVS_W-1:0]    dvs;
  logic [frm_pkg::DVD_W-1:0]    quot;
  logic                         div_done;

  logic [frm_pkg::TIME_W:0]     elapsed_p1;
  logic [26:0]                  lim_prod;

  frm_ram #(
    .WIDTH (frm_pkg::TIME_W),
    .DEPTH (frm_pkg::WINDOW_LEN),
    .AW    (frm_pkg::SLOT_W)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_q),
    .wdata_i (elapsed_q),
    .re_i    (cmd_i.cap_in),
    .raddr_i (slot_q),
    .rdata_o (old_time)
  );

  always_comb begin
    unique case (cmd_i.op)
      frm_pkg::OP_AVG: begin
        dvd = {sum_q, 8'd0};
        dvs = frm_pkg::DVS_W'(filled_q);
      end
      frm_pkg::OP_RATE: begin
        dvd = frm_pkg::DVD_W'(frm_pkg::RATE_LIMIT) * frm_pkg::DVD_W'(filled_q);
        dvs = sum_q;
      end
      frm_pkg::OP_LIM: begin
        dvd = frm_pkg::DVD_W'(frm_pkg::PERIOD_NUM);
        dvs = frm_pkg::DVS_W'(target_q);
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  frm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign full     = filled_q >= frm_pkg::FILL_W'(frm_pkg::WINDOW_LEN);
  assign sum_base = full ? sum_q - frm_pkg::SUM_W'(old_time) : sum_q;
  assign sum_d    = sum_base + frm_pkg::SUM_W'(elapsed_q);

  always_comb begin
    if (req_q) begin
      idle_frames_d = '0;
    end else if (idle_frames_q != '1) begin
      idle_frames_d = idle_frames_q + 1'b1;
    end else begin
      idle_frames_d = idle_frames_q;
    end
  end

  // limiter sleeps only if the period exceeds elapsed by more than 1 ms
  assign elapsed_p1 = {1'b0, elapsed_q} + 1'b1;
  assign lim_prod   = 27'(target_q) * 27'(elapsed_p1);

  assign status_o.div_done    = div_done;
  assign status_o.sum_zero    = sum_q == '0;
  assign status_o.wait_needed = !vsync_q && (target_q != '0)
                                && (lim_prod < 27'(frm_pkg::PERIOD_NUM));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= '0;
      vsync_q       <= 1'b0;
      idle_limit_q  <= frm_pkg::IDLE_LIMIT_RST;
      sum_q         <= '0;
      filled_q      <= '0;
      slot_q        <= '0;
      idle_frames_q <= '0;
      frame_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == frm_pkg::CFG_TARGET) begin
          target_q <= cfg_data_i[frm_pkg::TARGET_W-1:0];
        end else if (cfg_index_i == frm_pkg::CFG_VSYNC) begin
          vsync_q <= cfg_data_i[0];
        end else if (cfg_index_i == frm_pkg::CFG_IDLE) begin
          idle_limit_q <= cfg_data_i[frm_pkg::IDLE_W-1:0];
        end
      end
      if (cmd_i.update) begin
        sum_q         <= sum_d;
        idle_frames_q <= idle_frames_d;
        frame_cnt_q   <= frame_cnt_q + 1'b1;
        if (!full) begin
          filled_q <= filled_q + 1'b1;
        end
        if (slot_q == frm_pkg::SLOT_W'(frm_pkg::WINDOW_LEN - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      elapsed_q <= frame_elapsed_i;
      req_q     <= redraw_requested_i;
    end
    if (cmd_i.update) begin
      is_idle_q <= !req_q && (idle_frames_d >= idle_limit_q);
    end
    if (cmd_i.cap) begin
      unique case (cmd_i.op)
        frm_pkg::OP_AVG: begin
          avg_q <= quot[frm_pkg::AVG_W-1:0];
        end
        frm_pkg::OP_RATE: begin
          if (cmd_i.zero) begin
            rate_q <= '0;
          end else if (quot > frm_pkg::DVD_W'(frm_pkg::RATE_LIMIT)) begin
            rate_q <= frm_pkg::RATE_LIMIT;
          end else begin
            rate_q <= quot[frm_pkg::RATE_W-1:0];
          end
        end
        frm_pkg::OP_LIM: begin
          if (cmd_i.zero) begin
            wait_q <= '0;
          end else begin
            wait_q <= quot[frm_pkg::WAIT_W-1:0] - elapsed_q[frm_pkg::WAIT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.load_out) begin
      avg_out_q     <= avg_q;
      rate_out_q    <= rate_q;
      wait_out_q    <= wait_q;
      idle_out_q    <= idle_frames_q;
      is_idle_out_q <= is_idle_q;
      frames_out_q  <= frame_cnt_q;
    end
  end

  assign average_time_q8_o = avg_out_q;
  assign rate_q8_o         = rate_out_q;
  assign wait_time_o       = wait_out_q;
  assign idle_count_o      = idle_out_q;
  assign is_idle_o         = is_idle_out_q;
  assign frames_total_o    = frames_out_q;

endmodule

>>> rtl/core/frm_ctrl.sv
module frm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output frm_pkg::ctrl_cmd_t    cmd_o,
  input  frm_pkg::ctrl_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV_GO,
    S_DIV_RUN,
    S_OUTPUT
  } state_e;

  state_e         state_q;
  frm_pkg::op_e   op_q;
  frm_pkg::op_e   next_op;
  logic           out_valid_q;
  logic           skip;
  logic           last_op;

  // rate needs a nonzero sum, the limiter division only runs when a wait is due
  assign skip = ((op_q == frm_pkg::OP_RATE) && status_i.sum_zero)
             || ((op_q == frm_pkg::OP_LIM) && !status_i.wait_needed);
  assign last_op = op_q == frm_pkg::OP_LIM;

  always_comb begin
    unique case (op_q)
      frm_pkg::OP_AVG:  next_op = frm_pkg::OP_RATE;
      frm_pkg::OP_RATE: next_op = frm_pkg::OP_LIM;
      default:          next_op = frm_pkg::OP_AVG;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      S_IDLE:    cmd_o.cap_in = in_valid_i;
      S_UPDATE:  cmd_o.update = 1'b1;
      S_DIV_GO: begin
        if (skip) begin
          cmd_o.cap  = 1'b1;
          cmd_o.zero = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_DIV_RUN: cmd_o.cap      = status_i.div_done;
      S_OUTPUT:  cmd_o.load_out = !out_valid_q || !out_stall_i;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= frm_pkg::OP_AVG;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          op_q    <= frm_pkg::OP_AVG;
          state_q <= S_DIV_GO;
        end
        S_DIV_GO, S_DIV_RUN: begin
          if (cmd_o.cap) begin
            if (last_op) begin
              state_q <= S_OUTPUT;
            end else begin
              op_q    <= next_op;
              state_q <= S_DIV_GO;
            end
          end else if (cmd_o.div_start) begin
            state_q <= S_DIV_RUN;
          end
        end
        S_OUTPUT: begin
          if (cmd_o.load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/frame_rate_monitor_top.sv
// Frame rate monitor: one input word per finished frame (elapsed ms and a
// redraw flag), one result word back per frame.
// Input channel: in_valid_i / in_stall_o; a word is taken when valid is high
// and stall is low. Result channel: out_valid_o / out_stall_i, same rule.
// Config: cfg_we_i writes cfg_data_i into register cfg_index_i (0 target
// rate, 1 vsync, 2 idle limit); write only while no frame is in flight.
// All three quotients (average, rate, limiter period) go through one shared
// restoring divider, 30 steps each; the rate division is skipped when the
// window sum is zero and the limiter division when no wait is due.
// Throughput: one frame at a time; in_stall_o is high from the cycle after
// acceptance until the result is loaded into the output register.
// The output register frees the input side: the next frame is accepted while
// a result waits, and is held finished in the controller if out_stall_i stays
// high. A stalled result holds its value.
// Reset clears the window, counters and config (idle limit 10); the history
// memory needs no clearing since only written slots are read.
module frame_rate_monitor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [frm_pkg::TIME_W-1:0]     frame_elapsed_i,
  input  logic                           redraw_requested_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [frm_pkg::AVG_W-1:0]      average_time_q8_o,
  output logic [frm_pkg::RATE_W-1:0]     rate_q8_o,
  output logic [frm_pkg::WAIT_W-1:0]     wait_time_o,
  output logic [frm_pkg::IDLE_W-1:0]     idle_count_o,
  output logic                           is_idle_o,
  output logic [frm_pkg::FRAMES_W-1:0]   frames_total_o,
  input  logic                           cfg_we_i,
  input  logic [frm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  frm_pkg::ctrl_cmd_t    cmd;
  frm_pkg::ctrl_status_t status;

  frm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  frm_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .frame_elapsed_i    (frame_elapsed_i),
    .redraw_requested_i (redraw_requested_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .average_time_q8_o  (average_time_q8_o),
    .rate_q8_o          (rate_q8_o),
    .wait_time_o        (wait_time_o),
    .idle_count_o       (idle_count_o),
    .is_idle_o          (is_idle_o),
    .frames_total_o     (frames_total_o)
  );

endmodule

>>> rtl/core/frm_checker.sv
module frm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [frm_pkg::AVG_W-1:0]      average_time_q8_o,
  input logic [frm_pkg::RATE_W-1:0]     rate_q8_o,
  input logic [frm_pkg::WAIT_W-1:0]     wait_time_o,
  input logic [frm_pkg::FRAMES_W-1:0]   frames_total_o
);

  // one frame in flight: after a word is taken the input stalls
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rate_q8_o <= frm_pkg::RATE_LIMIT)
                    && (wait_time_o <= frm_pkg::PERIOD_NUM))
    else $error("rate or wait out of range");

  // zero average means zero window sum, which forces a zero rate and vice versa
  a_avg_rate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((average_time_q8_o == '0) == (rate_q8_o == '0)))
    else $error("average and rate disagree on zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frames_total_o))
    else $error("stalled result changed");

endmodule

bind frame_rate_monitor_top frm_checker u_frm_checker (.*);
